@@ hdl/dteq_pkg.sv @@
`timescale 1ns / 1ps

package dteq_pkg;

  // operation selector carried in the input item
  typedef enum logic [1:0] {
    FN_SPAWN   = 2'd0,
    FN_DELAY   = 2'd1,
    FN_ADVANCE = 2'd2,
    FN_FINISH  = 2'd3
  } fn_t;

  // result status codes
  typedef enum logic [2:0] {
    RS_DONE       = 3'd0,
    RS_DISPATCHED = 3'd1,
    RS_EMPTY      = 3'd2,
    RS_FULL       = 3'd3,
    RS_NO_CURRENT = 3'd4
  } status_t;

  // what the cell row does in one cycle
  typedef enum logic [2:0] {
    CO_IDLE   = 3'd0,
    CO_PUSH   = 3'd1,
    CO_POP    = 3'd2,
    CO_CLEAR  = 3'd3,
    CO_SCAN   = 3'd4,
    CO_INSERT = 3'd5
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     inject;
  } cell_cmd_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } ctrl_state_t;

  localparam int unsigned TICK_BITS = 32;
  localparam int unsigned TIME_BITS = 64;
  localparam int unsigned PID_BITS  = 8;

endpackage

@@ hdl/dteq_cell.sv @@
`timescale 1ns / 1ps

module dteq_cell #(
  parameter int unsigned ID_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dteq_pkg::cell_cmd_t        cmd,
  input  logic [ID_BITS-1:0]         new_id,
  input  logic [ID_BITS-1:0]         left_id,
  input  logic [dteq_pkg::TICK_BITS-1:0] left_dlt,
  input  logic                       left_vld,
  input  logic                       left_tok,
  input  logic [dteq_pkg::TICK_BITS-1:0] left_rem,
  input  logic [ID_BITS-1:0]         right_id,
  input  logic [dteq_pkg::TICK_BITS-1:0] right_dlt,
  input  logic                       right_vld,
  output logic [ID_BITS-1:0]         id_o,
  output logic [dteq_pkg::TICK_BITS-1:0] dlt_o,
  output logic                       vld_o,
  output logic                       tok_o,
  output logic [dteq_pkg::TICK_BITS-1:0] rem_o,
  output logic                       ins_o
);
  import dteq_pkg::*;

  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TICK_BITS-1:0] dlt_r, dlt_nxt;
  logic [TICK_BITS-1:0] rem_r, rem_nxt;
  logic                 vld_r, vld_nxt;
  logic                 tok_r, tok_nxt;
  logic                 ins_r, ins_nxt;
  logic                 pass_r, pass_nxt;
  logic                 stop;

  // the walk stops here when this slot is free or its delta exceeds the remainder
  assign stop  = !vld_r || (dlt_r > rem_r);
  assign id_o  = id_r;
  assign vld_o = vld_r;
  assign ins_o = ins_r;
  assign tok_o = tok_r && !stop;
  assign rem_o = rem_r - dlt_r;
  // entry pushed behind an insert gives up the remainder from its delta
  assign dlt_o = ins_r ? (dlt_r - rem_r) : dlt_r;

  // next value of the cell
  always_comb begin
    id_nxt   = id_r;
    dlt_nxt  = dlt_r;
    rem_nxt  = rem_r;
    vld_nxt  = vld_r;
    tok_nxt  = 1'b0;
    ins_nxt  = 1'b0;
    pass_nxt = 1'b0;
    unique case (cmd.op)
      CO_IDLE: begin
      end
      CO_PUSH: begin
        id_nxt  = left_id;
        dlt_nxt = left_dlt;
        vld_nxt = left_vld;
      end
      CO_POP: begin
        id_nxt  = right_id;
        dlt_nxt = right_dlt;
        vld_nxt = right_vld;
      end
      CO_CLEAR: begin
        vld_nxt = 1'b0;
      end
      CO_SCAN: begin
        ins_nxt  = ins_r;
        pass_nxt = pass_r;
        if (tok_r) begin
          if (stop) begin
            ins_nxt = 1'b1;
          end else begin
            pass_nxt = 1'b1;
          end
        end else if (left_tok) begin
          tok_nxt = 1'b1;
          rem_nxt = left_rem;
        end
      end
      CO_INSERT: begin
        priority if (pass_r) begin
        end else if (ins_r) begin
          id_nxt  = new_id;
          dlt_nxt = rem_r;
          vld_nxt = 1'b1;
        end else begin
          id_nxt  = left_id;
          dlt_nxt = left_dlt;
          vld_nxt = left_vld;
        end
      end
      default: begin
      end
    endcase
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      tok_r  <= 1'b0;
      ins_r  <= 1'b0;
      pass_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      tok_r  <= tok_nxt;
      ins_r  <= ins_nxt;
      pass_r <= pass_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    dlt_r <= dlt_nxt;
    rem_r <= rem_nxt;
  end

endmodule

@@ hdl/dteq_ctrl.sv @@
`timescale 1ns / 1ps

module dteq_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        acc,
  input  dteq_pkg::fn_t               func,
  output logic                        busy,
  input  logic [ID_BITS-1:0]          head_id,
  input  logic [dteq_pkg::TICK_BITS-1:0] head_dlt,
  input  logic                        found,
  output dteq_pkg::cell_cmd_t         cmd,
  output logic [ID_BITS-1:0]          cur_id,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output dteq_pkg::status_t           out_status,
  output logic [dteq_pkg::PID_BITS-1:0]  out_disp,
  output logic [dteq_pkg::TIME_BITS-1:0] out_now
);
  import dteq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  ctrl_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [ID_BITS-1:0]   cur_id_r, cur_id_nxt;
  logic                 cur_vld_r, cur_vld_nxt;
  logic                 pend_vld_r;
  status_t              pend_st_r;
  logic [PID_BITS-1:0]  pend_disp_r;
  logic [TIME_BITS-1:0] pend_now_r;
  logic                 out_vld_r;
  status_t              out_st_r;
  logic [PID_BITS-1:0]  out_disp_r;
  logic [TIME_BITS-1:0] out_now_r;
  logic                 res_set;
  status_t              res_st;
  logic [PID_BITS-1:0]  res_disp;
  logic                 full;
  logic                 move;

  assign full   = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign busy   = (state_r != S_IDLE) || pend_vld_r;
  assign cur_id = cur_id_r;
  assign move   = pend_vld_r && (!out_vld_r || out_tready);

  assign out_tvalid = out_vld_r;
  assign out_status = out_st_r;
  assign out_disp   = out_disp_r;
  assign out_now    = out_now_r;

  // operation sequencing
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    time_nxt    = time_r;
    cur_id_nxt  = cur_id_r;
    cur_vld_nxt = cur_vld_r;
    cmd.op      = CO_IDLE;
    cmd.inject  = 1'b0;
    res_set     = 1'b0;
    res_st      = RS_DONE;
    res_disp    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          res_set = 1'b1;
          unique case (func)
            FN_SPAWN: begin
              if (full) begin
                res_st = RS_FULL;
              end else begin
                cmd.op  = CO_PUSH;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            FN_DELAY: begin
              priority if (!cur_vld_r) begin
                res_st = RS_NO_CURRENT;
              end else if (full) begin
                res_st      = RS_FULL;
                cur_vld_nxt = 1'b0;
              end else begin
                res_set     = 1'b0;
                cmd.op      = CO_SCAN;
                cmd.inject  = 1'b1;
                cur_vld_nxt = 1'b0;
                state_nxt   = S_SCAN;
              end
            end
            FN_ADVANCE: begin
              if (cnt_r == '0) begin
                res_st      = RS_EMPTY;
                cur_vld_nxt = 1'b0;
              end else begin
                cmd.op      = CO_POP;
                cnt_nxt     = cnt_r - 1'b1;
                time_nxt    = time_r + TIME_BITS'(head_dlt);
                cur_id_nxt  = head_id;
                cur_vld_nxt = 1'b1;
                res_st      = RS_DISPATCHED;
                res_disp    = PID_BITS'(head_id);
              end
            end
            FN_FINISH: begin
              cmd.op  = CO_CLEAR;
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (found) begin
          cmd.op    = CO_INSERT;
          cnt_nxt   = cnt_r + 1'b1;
          res_set   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.op = CO_SCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      time_r     <= '0;
      cur_id_r   <= '0;
      cur_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      time_r    <= time_nxt;
      cur_id_r  <= cur_id_nxt;
      cur_vld_r <= cur_vld_nxt;
      if (res_set) begin
        pend_vld_r <= 1'b1;
      end else if (move) begin
        pend_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // result payload: pending slot, then output register
  always_ff @(posedge clk) begin
    if (res_set) begin
      pend_st_r   <= res_st;
      pend_disp_r <= res_disp;
      pend_now_r  <= time_nxt;
    end
    if (move) begin
      out_st_r   <= pend_st_r;
      out_disp_r <= pend_disp_r;
      out_now_r  <= pend_now_r;
    end
  end

endmodule

@@ hdl/delta_timer_event_queue.sv @@
`timescale 1ns / 1ps

// channel | dir | tdata                              | tuser
// in_     | in  | [7:0] proc_id, [39:8] ticks        | [1:0] func
// out_    | out | [7:0] dispatched_id, [71:8] now    | [2:0] status
//
// Spawn, advance, finish and rejected operations finish in the idle state. A delay
// walks a token along the cell row, one cell per cycle, until it reaches the
// insertion position.
// out_tvalid rises once a finished item has passed the pending slot and then the
// output register; in_tready is low while a delay walks or the pending slot is full.
// Synchronous reset empties the queue, zeroes time and drops the current process.
module delta_timer_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // proc_id, ticks
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // dispatched_id, now
  output logic [2:0]  out_tuser   // status
);
  import dteq_pkg::*;

  logic                 busy;
  logic                 acc;
  cell_cmd_t            cmd;
  logic [ID_BITS-1:0]   cur_id;
  logic [ID_BITS-1:0]   in_id;
  logic [TICK_BITS-1:0] in_ticks;
  status_t              res_st;
  logic [PID_BITS-1:0]  res_disp;
  logic [TIME_BITS-1:0] res_now;

  logic [ID_BITS-1:0]   id_w  [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] dlt_w [QUEUE_DEPTH];
  logic [TICK_BITS-1:0] rem_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] vld_w;
  logic [QUEUE_DEPTH-1:0] tok_w;
  logic [QUEUE_DEPTH-1:0] ins_w;

  assign in_tready = !busy;
  assign acc       = in_tvalid && in_tready;
  assign in_id     = ID_BITS'(in_tdata[PID_BITS-1:0]);
  assign in_ticks  = in_tdata[PID_BITS +: TICK_BITS];

  assign out_tuser = res_st;
  assign out_tdata = {res_now, res_disp};

  // row of queue cells, head at cell 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0]   l_id, r_id;
    logic [TICK_BITS-1:0] l_dlt, r_dlt, l_rem;
    logic                 l_vld, r_vld, l_tok;

    if (i == 0) begin : g_head
      assign l_id  = in_id;
      assign l_dlt = in_ticks;
      assign l_vld = 1'b1;
      assign l_tok = cmd.inject;
      assign l_rem = in_ticks;
    end else begin : g_body
      assign l_id  = id_w[i-1];
      assign l_dlt = dlt_w[i-1];
      assign l_vld = vld_w[i-1];
      assign l_tok = tok_w[i-1];
      assign l_rem = rem_w[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign r_id  = '0;
      assign r_dlt = '0;
      assign r_vld = 1'b0;
    end else begin : g_mid
      assign r_id  = id_w[i+1];
      assign r_dlt = dlt_w[i+1];
      assign r_vld = vld_w[i+1];
    end

    dteq_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .new_id    (cur_id),
      .left_id   (l_id),
      .left_dlt  (l_dlt),
      .left_vld  (l_vld),
      .left_tok  (l_tok),
      .left_rem  (l_rem),
      .right_id  (r_id),
      .right_dlt (r_dlt),
      .right_vld (r_vld),
      .id_o      (id_w[i]),
      .dlt_o     (dlt_w[i]),
      .vld_o     (vld_w[i]),
      .tok_o     (tok_w[i]),
      .rem_o     (rem_w[i]),
      .ins_o     (ins_w[i])
    );
  end

  // sequencer, time counter and result registers
  dteq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .func       (fn_t'(in_tuser)),
    .busy       (busy),
    .head_id    (id_w[0]),
    .head_dlt   (dlt_w[0]),
    .found      (|ins_w),
    .cmd        (cmd),
    .cur_id     (cur_id),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (res_st),
    .out_disp   (res_disp),
    .out_now    (res_now)
  );

endmodule
